[rtl/core/kct_pkg.sv]
// Shared types, constants and micro-program of the Kalman tracker core
`default_nettype none
package kct_pkg;

	localparam int unsigned RAM_DEPTH = 128;
	localparam int unsigned RA_W      = 7;

	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_PRED = 2'd1;
	localparam logic [1:0] OP_CORR = 2'd2;

	localparam logic       CFG_PNOISE = 1'b0;
	localparam logic       CFG_MNOISE = 1'b1;
	localparam logic [15:0] PNOISE_RST = 16'd655;
	localparam logic [15:0] MNOISE_RST = 16'd6554;

	// scratch map
	localparam logic [RA_W-1:0] A_X    = 7'd0;
	localparam logic [RA_W-1:0] A_P    = 7'd4;
	localparam logic [RA_W-1:0] A_T    = 7'd20;
	localparam logic [RA_W-1:0] A_IKH  = 7'd36;
	localparam logic [RA_W-1:0] A_INN  = 7'd52;
	localparam logic [RA_W-1:0] A_S    = 7'd54;
	localparam logic [RA_W-1:0] A_N    = 7'd58;
	localparam logic [RA_W-1:0] A_SINV = 7'd60;
	localparam logic [RA_W-1:0] A_K    = 7'd64;
	localparam logic [RA_W-1:0] A_KY   = 7'd72;

	// program segment bounds
	localparam logic [7:0] PC_INIT = 8'd0;
	localparam logic [7:0] PC_PRED = 8'd20;
	localparam logic [7:0] PC_CA   = 8'd58;
	localparam logic [7:0] PC_CB   = 8'd66;
	localparam logic [7:0] PC_END  = 8'd196;

	typedef enum logic [1:0] {K_ADD, K_SUB, K_MAC} kind_t;
	typedef enum logic [2:0] {
		SRC_RAM, SRC_ONE, SRC_ZERO, SRC_Q, SRC_R, SRC_ZX, SRC_ZY, SRC_INV
	} src_t;
	typedef enum logic [2:0] {ST_RUN, ST_DRAIN, ST_DIV, ST_FINISH, ST_IDLE} state_t;
	typedef enum logic [1:0] {SEG_INIT, SEG_PRED, SEG_CA, SEG_CB} seg_t;

	typedef struct packed {
		kind_t           kind;
		src_t            sa;
		src_t            sb;
		logic [RA_W-1:0] ra;
		logic [RA_W-1:0] rb;
		logic [RA_W-1:0] wd;
		logic            first;
		logic            last;
		logic            neg;
		logic            wen;
		logic            barrier;
	} uop_t;

	typedef struct packed {
		logic issue;
		uop_t uop;
		logic capture;
		logic div_start;
		logic load_out;
		logic sing;
	} kct_cmd_t;

	typedef struct packed {
		logic busy;
		logic det_zero;
		logic div_done;
		logic out_full;
	} kct_sts_t;

	function automatic uop_t prog_f(input logic [7:0] pc);
		uop_t       u;
		logic [7:0] p;
		logic [3:0] q;
		logic [5:0] r;
		logic [2:0] o;
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] t;
		u = '{kind: K_ADD, sa: SRC_RAM, sb: SRC_ZERO, ra: '0, rb: '0, wd: '0,
			first: 1'b1, last: 1'b1, neg: 1'b0, wen: 1'b1, barrier: 1'b0};
		p = 8'd0; q = 4'd0; r = 6'd0; o = 3'd0; i = 2'd0; j = 2'd0; t = 2'd0;
		if (pc < PC_PRED) begin
			p = pc - PC_INIT;
			if (p < 8'd4) begin
				u.sa = (p == 8'd0) ? SRC_ZX : ((p == 8'd1) ? SRC_ZY : SRC_ZERO);
				u.wd = A_X + RA_W'(p);
			end else begin
				q = 4'(p - 8'd4);
				u.sa = (q == 4'd0 || q == 4'd5 || q == 4'd10 || q == 4'd15) ?
					SRC_ONE : SRC_ZERO;
				u.wd = A_P + RA_W'(q);
			end
		end else if (pc < PC_CA) begin
			p = pc - PC_PRED;
			if (p < 8'd2) begin
				u.ra = A_X + RA_W'(p);
				u.sb = SRC_RAM;
				u.rb = A_X + RA_W'(p) + 7'd2;
				u.wd = A_X + RA_W'(p);
			end else if (p < 8'd18) begin
				q = 4'(p - 8'd2);
				i = q[3:2];
				u.ra = A_P + RA_W'(q);
				u.wd = A_T + RA_W'(q);
				if (i < 2'd2) begin
					u.sb = SRC_RAM;
					u.rb = A_P + RA_W'(q) + 7'd8;
				end
			end else if (p < 8'd34) begin
				q = 4'(p - 8'd18);
				j = q[1:0];
				u.ra = A_T + RA_W'(q);
				u.wd = A_P + RA_W'(q);
				u.barrier = (q == 4'd0);
				if (j < 2'd2) begin
					u.sb = SRC_RAM;
					u.rb = A_T + RA_W'(q) + 7'd2;
				end
			end else begin
				i = 2'(p - 8'd34);
				u.ra = A_P + RA_W'({i, 2'b00}) + RA_W'(i);
				u.wd = A_P + RA_W'({i, 2'b00}) + RA_W'(i);
				u.sb = SRC_Q;
				u.barrier = (i == 2'd0);
			end
		end else if (pc < PC_CB) begin
			p = pc - PC_CA;
			case (p)
				8'd0: begin
					u.kind = K_SUB; u.sa = SRC_ZX; u.sb = SRC_RAM; u.rb = A_X; u.wd = A_INN;
				end
				8'd1: begin
					u.kind = K_SUB; u.sa = SRC_ZY; u.sb = SRC_RAM;
					u.rb = A_X + 7'd1; u.wd = A_INN + 7'd1;
				end
				8'd2: begin
					u.ra = A_P; u.sb = SRC_R; u.wd = A_S;
				end
				8'd3: begin
					u.ra = A_P + 7'd1; u.wd = A_S + 7'd1;
				end
				8'd4: begin
					u.ra = A_P + 7'd4; u.wd = A_S + 7'd2;
				end
				8'd5: begin
					u.ra = A_P + 7'd5; u.sb = SRC_R; u.wd = A_S + 7'd3;
				end
				8'd6: begin
					u.kind = K_MAC; u.sb = SRC_RAM; u.ra = A_S; u.rb = A_S + 7'd3;
					u.last = 1'b0; u.wen = 1'b0; u.barrier = 1'b1;
				end
				default: begin
					u.kind = K_MAC; u.sb = SRC_RAM; u.ra = A_S + 7'd1; u.rb = A_S + 7'd2;
					u.first = 1'b0; u.neg = 1'b1; u.wen = 1'b0;
				end
			endcase
		end else begin
			p = pc - PC_CB;
			if (p < 8'd2) begin
				u.kind = K_SUB; u.sa = SRC_ZERO; u.sb = SRC_RAM;
				u.rb = A_S + 7'd1 + RA_W'(p);
				u.wd = A_N + RA_W'(p);
			end else if (p < 8'd6) begin
				u.kind = K_MAC; u.sb = SRC_INV;
				u.wd = A_SINV + RA_W'(p - 8'd2);
				u.barrier = (p == 8'd2);
				case (p)
					8'd2:    u.ra = A_S + 7'd3;
					8'd3:    u.ra = A_N;
					8'd4:    u.ra = A_N + 7'd1;
					default: u.ra = A_S;
				endcase
			end else if (p < 8'd22) begin
				q = 4'(p - 8'd6);
				o = q[3:1]; t = {1'b0, q[0]};
				i = o[2:1]; j = {1'b0, o[0]};
				u.kind = K_MAC; u.sb = SRC_RAM;
				u.ra = A_P + RA_W'({i, 1'b0, t[0]});
				u.rb = A_SINV + RA_W'({t[0], j[0]});
				u.wd = A_K + RA_W'(o);
				u.first = ~t[0]; u.last = t[0];
				u.barrier = (q == 4'd0);
			end else if (p < 8'd30) begin
				o = 3'(p - 8'd22);
				i = o[2:1]; t = {1'b0, o[0]};
				u.kind = K_MAC; u.sb = SRC_RAM;
				u.ra = A_K + RA_W'({i, t[0]});
				u.rb = A_INN + RA_W'(t[0]);
				u.wd = A_KY + RA_W'(i);
				u.first = ~t[0]; u.last = t[0];
				u.barrier = (o == 3'd0);
			end else if (p < 8'd34) begin
				i = 2'(p - 8'd30);
				u.ra = A_X + RA_W'(i);
				u.sb = SRC_RAM;
				u.rb = A_KY + RA_W'(i);
				u.wd = A_X + RA_W'(i);
				u.barrier = (i == 2'd0);
			end else if (p < 8'd50) begin
				q = 4'(p - 8'd34);
				i = q[3:2]; j = q[1:0];
				u.kind = K_SUB;
				u.sa = (i == j) ? SRC_ONE : SRC_ZERO;
				u.sb = (j < 2'd2) ? SRC_RAM : SRC_ZERO;
				u.rb = A_K + RA_W'({i, j[0]});
				u.wd = A_IKH + RA_W'(q);
			end else if (p < 8'd114) begin
				r = 6'(p - 8'd50);
				i = r[5:4]; j = r[3:2]; t = r[1:0];
				u.kind = K_MAC; u.sb = SRC_RAM;
				u.ra = A_IKH + RA_W'({i, t});
				u.rb = A_P + RA_W'({t, j});
				u.wd = A_T + RA_W'(r[5:2]);
				u.first = (t == 2'd0); u.last = (t == 2'd3);
				u.barrier = (r == 6'd0);
			end else begin
				q = 4'(p - 8'd114);
				u.ra = A_T + RA_W'(q);
				u.wd = A_P + RA_W'(q);
				u.barrier = (q == 4'd0);
			end
		end
		return u;
	endfunction

endpackage
`default_nettype wire

[rtl/core/kct_if.sv]
// Item channels of the Kalman tracker core
`default_nettype none
interface kct_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	modport source (output valid, opcode, coord_x, coord_y, input ready);
	modport sink   (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface kct_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic signed [31:0] est_vx;
	logic signed [31:0] est_vy;
	logic               singular;
	modport source (output valid, est_x, est_y, est_vx, est_vy, singular, input ready);
	modport sink   (input valid, est_x, est_y, est_vx, est_vy, singular, output ready);
endinterface
`default_nettype wire

[rtl/core/kct_ram.sv]
// Generic RAM, one write port, two registered read ports
`default_nettype none
module kct_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

[rtl/core/kct_datapath.sv]
// Datapath: scratch RAM, multiply-accumulate pipe, divider, config and output registers
`default_nettype none
module kct_datapath import kct_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic               out_ready,
	input  wire kct_cmd_t           cmd,
	output kct_sts_t                sts,
	output logic                    out_valid,
	output logic signed [31:0]      est_x,
	output logic signed [31:0]      est_y,
	output logic signed [31:0]      est_vx,
	output logic signed [31:0]      est_vy,
	output logic                    singular
);
	localparam int unsigned W   = WORD_WIDTH;
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned AW  = W + 2;
	localparam int unsigned PW  = 2 * W;
	localparam int unsigned NB  = 2 * F + 1;
	localparam int unsigned DCW = $clog2(NB + 1);
	localparam int unsigned QX  = ((NB > W) ? NB : W) + 1;
	localparam int unsigned CW  = (W > 32) ? W : 32;

	function automatic logic signed [W-1:0] sat_p(input logic signed [PW:0] v);
		return (v[PW:W-1] == {(PW-W+2){v[PW]}}) ? v[W-1:0] : {v[PW], {(W-1){~v[PW]}}};
	endfunction
	function automatic logic signed [W-1:0] sat_a(input logic signed [AW-1:0] v);
		return (v[AW-1:W-1] == {(AW-W+1){v[AW-1]}}) ? v[W-1:0] :
			{v[AW-1], {(W-1){~v[AW-1]}}};
	endfunction
	function automatic logic signed [W-1:0] sat_s(input logic signed [W:0] v);
		return (v[W] == v[W-1]) ? v[W-1:0] : {v[W], {(W-1){~v[W]}}};
	endfunction
	function automatic logic signed [W-1:0] sat_c(input logic signed [CW-1:0] v);
		return (v[CW-1:W-1] == {(CW-W+1){v[CW-1]}}) ? v[W-1:0] :
			{v[CW-1], {(W-1){~v[CW-1]}}};
	endfunction
	function automatic logic signed [W-1:0] sat_q(input logic signed [QX-1:0] v);
		return (v[QX-1:W-1] == {(QX-W+1){v[QX-1]}}) ? v[W-1:0] :
			{v[QX-1], {(W-1){~v[QX-1]}}};
	endfunction
	function automatic logic signed [31:0] sat_o(input logic signed [W-1:0] x);
		logic signed [CW-1:0] v;
		v = CW'(x);
		return (v[CW-1:31] == {(CW-31){v[CW-1]}}) ? v[31:0] : {v[CW-1], {31{~v[CW-1]}}};
	endfunction

	logic [15:0]            pnoise_q;
	logic [15:0]            mnoise_q;
	logic signed [W-1:0]    zx_q;
	logic signed [W-1:0]    zy_q;
	logic signed [W-1:0]    est_q [4];
	logic signed [W-1:0]    res_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [W-1:0]    inv_q;
	logic [W-1:0]           mag_q;
	logic [W-1:0]           rem_q;
	logic [NB-1:0]          quo_q;
	logic [DCW-1:0]         cnt_q;
	logic                   dneg_q;
	logic                   out_valid_q;
	logic signed [31:0]     out_q [4];
	logic                   sing_q;

	uop_t                   uop_s1;
	uop_t                   uop_s2;
	logic                   v_s1;
	logic                   v_s2;
	logic signed [PW-1:0]   prod_s2;
	logic signed [W:0]      sum_s2;

	logic [W-1:0]           rd_a;
	logic [W-1:0]           rd_b;
	logic signed [W-1:0]    op_a;
	logic signed [W-1:0]    op_b;
	logic signed [PW:0]     rnd;
	logic signed [W-1:0]    term;
	logic signed [AW-1:0]   acc_next;
	logic signed [W-1:0]    result;
	logic                   ram_we;
	logic [W:0]             trial;
	logic                   qbit;
	logic signed [QX-1:0]   qx;

	kct_ram #(.WIDTH(W), .DEPTH(RAM_DEPTH)) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (uop_s2.wd),
		.wdata   (result),
		.raddr_a (cmd.uop.ra),
		.raddr_b (cmd.uop.rb),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	function automatic logic signed [W-1:0] pick(input src_t s, input logic [W-1:0] rd,
		input logic [15:0] qn, input logic [15:0] rn, input logic signed [W-1:0] zx,
		input logic signed [W-1:0] zy, input logic signed [W-1:0] inv);
		logic signed [W-1:0] v;
		case (s)
			SRC_RAM:  v = rd;
			SRC_ONE:  v = W'(1) << F;
			SRC_ZERO: v = '0;
			SRC_Q:    v = W'(qn);
			SRC_R:    v = W'(rn);
			SRC_ZX:   v = zx;
			SRC_ZY:   v = zy;
			SRC_INV:  v = inv;
			default:  v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		op_a     = pick(uop_s1.sa, rd_a, pnoise_q, mnoise_q, zx_q, zy_q, inv_q);
		op_b     = pick(uop_s1.sb, rd_b, pnoise_q, mnoise_q, zx_q, zy_q, inv_q);
		rnd      = ((PW+1)'(prod_s2) + ((PW+1)'(1) << (F - 1))) >>> F;
		term     = sat_p(rnd);
		acc_next = (uop_s2.first ? AW'(0) : acc_q) + (uop_s2.neg ? -AW'(term) : AW'(term));
		result   = (uop_s2.kind == K_MAC) ? sat_a(acc_next) : sat_s(sum_s2);
		ram_we   = v_s2 && uop_s2.last && uop_s2.wen;
		trial    = {rem_q, (cnt_q == DCW'(NB))};
		qbit     = (trial >= {1'b0, mag_q});
		qx       = $signed(QX'(quo_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnoise_q    <= PNOISE_RST;
			mnoise_q    <= MNOISE_RST;
			zx_q        <= '0;
			zy_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PNOISE: pnoise_q <= cfg_wdata;
					CFG_MNOISE: mnoise_q <= cfg_wdata;
					default:    pnoise_q <= pnoise_q;
				endcase
			end
			if (cmd.capture) begin
				zx_q <= sat_c(CW'(coord_x));
				zy_q <= sat_c(CW'(coord_y));
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.div_start) begin
				cnt_q <= DCW'(NB);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DCW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		uop_s1  <= cmd.uop;
		uop_s2  <= uop_s1;
		prod_s2 <= op_a * op_b;
		sum_s2  <= (uop_s1.kind == K_SUB) ? (op_a - op_b) : (op_a + op_b);
		if (v_s2 && uop_s2.kind == K_MAC) begin
			acc_q <= acc_next;
		end
		if (v_s2 && uop_s2.last) begin
			res_q <= result;
		end
		if (ram_we && uop_s2.wd < 7'd4) begin
			est_q[uop_s2.wd[1:0]] <= result;
		end
		if (cmd.div_start) begin
			mag_q  <= res_q[W-1] ? W'(-res_q) : W'(res_q);
			dneg_q <= res_q[W-1];
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? W'(trial - {1'b0, mag_q}) : trial[W-1:0];
			quo_q <= {quo_q[NB-2:0], qbit};
		end
		inv_q <= sat_q(dneg_q ? -qx : qx);
		if (cmd.load_out) begin
			for (int n = 0; n < 4; n++) begin
				out_q[n] <= sat_o(est_q[n]);
			end
			sing_q <= cmd.sing;
		end
	end

	always_comb begin
		sts.busy     = v_s1 || v_s2;
		sts.det_zero = (res_q == '0);
		sts.div_done = (cnt_q == '0);
		sts.out_full = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign est_x     = out_q[0];
	assign est_y     = out_q[1];
	assign est_vx    = out_q[2];
	assign est_vy    = out_q[3];
	assign singular  = sing_q;
endmodule
`default_nettype wire

[rtl/core/kct_ctrl.sv]
// Controller: sequences the micro-program, divider and result hand-off
`default_nettype none
module kct_ctrl import kct_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire kct_sts_t   sts,
	output kct_cmd_t        cmd
);
	state_t     state_q;
	state_t     state_d;
	logic [7:0] pc_q;
	logic [7:0] end_q;
	seg_t       seg_q;
	logic       sing_q;
	logic       boot_q;
	logic       accept;
	logic       drained;

	assign accept  = (state_q == ST_IDLE) && in_valid;
	assign drained = (state_q == ST_DRAIN) && !sts.busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (pc_q == end_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					if (seg_q == SEG_CA) state_d = sts.det_zero ? ST_FINISH : ST_DIV;
					else if (boot_q) state_d = ST_IDLE;
					else state_d = ST_FINISH;
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_RUN;
			end
			ST_FINISH: begin
				if (!sts.out_full) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (opcode == OP_INIT || opcode == OP_PRED || opcode == OP_CORR) ?
						ST_RUN : ST_FINISH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.uop       = prog_f(pc_q);
		cmd.issue     = (state_q == ST_RUN) && (pc_q != end_q) && !(cmd.uop.barrier && sts.busy);
		cmd.capture   = accept;
		cmd.div_start = drained && (seg_q == SEG_CA) && !sts.det_zero;
		cmd.load_out  = (state_q == ST_FINISH) && !sts.out_full;
		cmd.sing      = sing_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			pc_q    <= PC_INIT;
			end_q   <= PC_PRED;
			seg_q   <= SEG_INIT;
			sing_q  <= 1'b0;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sing_q <= 1'b0;
				case (opcode)
					OP_INIT: begin
						pc_q <= PC_INIT; end_q <= PC_PRED; seg_q <= SEG_INIT;
					end
					OP_PRED: begin
						pc_q <= PC_PRED; end_q <= PC_CA; seg_q <= SEG_PRED;
					end
					OP_CORR: begin
						pc_q <= PC_CA; end_q <= PC_CB; seg_q <= SEG_CA;
					end
					default: seg_q <= SEG_INIT;
				endcase
			end else if (cmd.issue) begin
				pc_q <= pc_q + 8'd1;
			end else if (state_q == ST_DIV && sts.div_done) begin
				pc_q <= PC_CB; end_q <= PC_END; seg_q <= SEG_CB;
			end
			if (drained && seg_q == SEG_CA && sts.det_zero) begin
				sing_q <= 1'b1;
			end
			if (drained && boot_q) begin
				boot_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/kalman_cv_tracker_2d_core.sv]
// Top level of the constant-velocity 2D Kalman tracker core
//
//   channel | dir | handshake      | payload
//   in_ch   | in  | valid / ready  | opcode, coord_x, coord_y
//   out_ch  | out | valid / ready  | est_x, est_y, est_vx, est_vy, singular
//   cfg     | in  | cfg_we         | cfg_index, cfg_wdata (no read-back)
//
// One item at a time through a shared multiply-accumulate pipe, one term a cycle,
// draining the three-stage pipe between dependent phases.
// Correction runs the restoring divider between its two program segments; a singular
// correction skips the divider and the second segment; opcode 3 only hands out the
// current estimate.
// After reset a 20-word initialisation pass runs before in_ch.ready.
// The result register lets the next item enter while a result waits on out_ch.
`default_nettype none
module kalman_cv_tracker_2d_core import kct_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	kct_in_if.sink           in_ch,
	kct_out_if.source        out_ch
);
	kct_cmd_t cmd;
	kct_sts_t sts;

	kct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.opcode   (in_ch.opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	kct_datapath #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coord_x   (in_ch.coord_x),
		.coord_y   (in_ch.coord_y),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.est_x     (out_ch.est_x),
		.est_y     (out_ch.est_y),
		.est_vx    (out_ch.est_vx),
		.est_vy    (out_ch.est_vy),
		.singular  (out_ch.singular)
	);
endmodule
`default_nettype wire

[tb/sv/kct_tb_checker.sv]
// Checker for the Kalman tracker core: predicts each estimate and compares it with the block's output
module kct_tb_checker import kct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_wdata,
	kct_in_if                in_ch,
	kct_out_if               out_ch,
	output int               fail_count,
	output int               pending_count,
	output int               result_count,
	output int               singular_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] ex, ey, evx, evy;
		logic               sing;
	} est_t;

	localparam longint W_MAX = 64'sd2147483647;
	localparam longint W_MIN = -64'sd2147483648;
	localparam longint ONE = 64'sd65536;

	est_t           est_q[$];
	longint         trk[4];
	longint         cov[16];
	longint unsigned q_noise, r_noise;

	function automatic longint clamp(longint v);
		if (v > W_MAX) return W_MAX;
		if (v < W_MIN) return W_MIN;
		return v;
	endfunction

	// exact product rounded half up at 16 fraction bits, then saturated
	function automatic longint fmul(longint a, longint b);
		logic signed [127:0] p;
		p = (128'(signed'(a)) * 128'(signed'(b)) + 128'sd32768) >>> 16;
		if (p > 128'sd2147483647) return W_MAX;
		if (p < -128'sd2147483648) return W_MIN;
		return longint'(p);
	endfunction

	function automatic void reset_cov();
		for (int i = 0; i < 16; i++) cov[i] = (i % 5 == 0) ? ONE : 0;
	endfunction

	function automatic void advance();
		longint t[16], n[16], s;
		trk[0] = clamp(trk[0] + trk[2]);
		trk[1] = clamp(trk[1] + trk[3]);
		// F*P: rows 0,1 gain rows 2,3
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				s = fmul(ONE, cov[i*4+j]);
				if (i < 2) s += fmul(ONE, cov[(i+2)*4+j]);
				t[i*4+j] = clamp(s);
			end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				s = fmul(t[i*4+j], ONE);
				if (j < 2) s += fmul(t[i*4+j+2], ONE);
				n[i*4+j] = clamp(s);
			end
		for (int i = 0; i < 16; i++) cov[i] = n[i];
		for (int i = 0; i < 4; i++) cov[i*5] = clamp(cov[i*5] + longint'(q_noise));
	endfunction

	function automatic bit fold_in(longint zx, longint zy);
		longint inn[2], sm[4], si[4], k[8], ky[4], ikh[16], np[16];
		longint det, inv, mag, acc;
		inn[0] = clamp(zx - trk[0]);
		inn[1] = clamp(zy - trk[1]);
		sm[0] = clamp(cov[0] + longint'(r_noise));
		sm[1] = cov[1];
		sm[2] = cov[4];
		sm[3] = clamp(cov[5] + longint'(r_noise));
		det = clamp(fmul(sm[0], sm[3]) - fmul(sm[1], sm[2]));
		if (det == 0) return 1'b1;
		mag = det < 0 ? -det : det;
		inv = longint'((64'd1 << 32) / unsigned'(mag));
		inv = clamp(det < 0 ? -inv : inv);
		si[0] = fmul(sm[3], inv);
		si[1] = fmul(clamp(-sm[1]), inv);
		si[2] = fmul(clamp(-sm[2]), inv);
		si[3] = fmul(sm[0], inv);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 2; j++)
				k[i*2+j] = clamp(fmul(cov[i*4], si[j]) + fmul(cov[i*4+1], si[2+j]));
		for (int i = 0; i < 4; i++)
			ky[i] = clamp(fmul(k[i*2], inn[0]) + fmul(k[i*2+1], inn[1]));
		for (int i = 0; i < 4; i++) trk[i] = clamp(trk[i] + ky[i]);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int t = 0; t < 2; t++)
					acc += fmul(k[i*2+t], (t == j) ? ONE : 0);
				ikh[i*4+j] = clamp(((i == j) ? ONE : 0) - clamp(acc));
			end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int t = 0; t < 4; t++) acc += fmul(ikh[i*4+t], cov[t*4+j]);
				np[i*4+j] = clamp(acc);
			end
		for (int i = 0; i < 16; i++) cov[i] = np[i];
		return 1'b0;
	endfunction

	function automatic est_t track_step(logic [1:0] op, logic signed [31:0] cx,
			logic signed [31:0] cy);
		est_t e;
		bit   sg;
		sg = 1'b0;
		case (op)
			OP_INIT: begin
				trk[0] = cx; trk[1] = cy; trk[2] = 0; trk[3] = 0;
				reset_cov();
			end
			OP_PRED: advance();
			OP_CORR: sg = fold_in(cx, cy);
			default: ;
		endcase
		e.ex = 32'(trk[0]); e.ey = 32'(trk[1]);
		e.evx = 32'(trk[2]); e.evy = 32'(trk[3]);
		e.sing = sg;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		est_t e, got;
		if (!arst_n) begin
			q_noise = PNOISE_RST;
			r_noise = MNOISE_RST;
			for (int i = 0; i < 4; i++) trk[i] = 0;
			reset_cov();
			est_q.delete();
			fail_count = 0;
			result_count = 0;
			singular_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_PNOISE) q_noise = cfg_wdata;
				else r_noise = cfg_wdata;
			end
			if (in_ch.valid && in_ch.ready)
				est_q.push_back(track_step(in_ch.opcode, in_ch.coord_x, in_ch.coord_y));
			if (out_ch.valid && out_ch.ready) begin
				got.ex = out_ch.est_x; got.ey = out_ch.est_y;
				got.evx = out_ch.est_vx; got.evy = out_ch.est_vy;
				got.sing = out_ch.singular;
				result_count++;
				if (est_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected estimate x=%0d y=%0d", $time, got.ex, got.ey);
				end else begin
					e = est_q.pop_front();
					if (e.sing) singular_count++;
					if (got.ex !== e.ex) begin
						fail_count++;
						$display("%0t: est_x exp %0d got %0d", $time, e.ex, got.ex);
					end
					if (got.ey !== e.ey) begin
						fail_count++;
						$display("%0t: est_y exp %0d got %0d", $time, e.ey, got.ey);
					end
					if (got.evx !== e.evx) begin
						fail_count++;
						$display("%0t: est_vx exp %0d got %0d", $time, e.evx, got.evx);
					end
					if (got.evy !== e.evy) begin
						fail_count++;
						$display("%0t: est_vy exp %0d got %0d", $time, e.evy, got.evy);
					end
					if (got.sing !== e.sing) begin
						fail_count++;
						$display("%0t: singular exp %0b got %0b", $time, e.sing, got.sing);
					end
				end
			end
		end
		pending_count = est_q.size();
	end
endmodule

[tb/sv/tb.sv]
// Testbench top for the Kalman tracker core: stimulus, configuration phases and verdict
module tb import kct_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS = 1450;
	localparam longint LIMIT = 3000000;

	logic        clk, arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;
	int          fail_count, pending_count, result_count, singular_count;
	longint      cycles;
	bit          rx_hold, calm;
	int          sent;

	kct_in_if  in_ch();
	kct_out_if out_ch();

	kalman_cv_tracker_2d_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
	);

	kct_tb_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count), .singular_count(singular_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver: random stalls, none while calm, a long hold when asked
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold) out_ch.ready <= 1'b0;
			else if (calm) out_ch.ready <= 1'b1;
			else out_ch.ready <= ($urandom_range(99) >= 30);
		end
	end

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom);
			default: return 32'(signed'($urandom_range(0, 400 << 16)) - (200 << 16));
		endcase
	endfunction

	task automatic send(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
		while (!calm && $urandom_range(99) < 30) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.coord_x <= x;
		in_ch.coord_y <= y;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic drain_and_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly a track: random inits, predicts and corrects with noisy measurements
	task automatic random_phase(int n);
		logic signed [31:0] px, py;
		int r;
		px = 0; py = 0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 6) begin
				px = rand_coord(); py = rand_coord();
				send(OP_INIT, px, py);
			end else if (r < 45) send(OP_PRED, 32'($urandom), 32'($urandom));
			else if (r < 88)
				send(OP_CORR, px + 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)),
					py + 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)));
			else if (r < 96) send(OP_CORR, rand_coord(), rand_coord());
			else send(2'd3, 32'($urandom), 32'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = CFG_PNOISE; cfg_wdata = '0;
		in_ch.valid = 1'b0; in_ch.opcode = OP_INIT;
		in_ch.coord_x = '0; in_ch.coord_y = '0;
		rx_hold = 1'b0; calm = 1'b0; sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every opcode, saturating innovation, unused opcode
		send(OP_PRED, 0, 0);
		send(OP_CORR, 32'sh7fffffff, 32'sh80000000);
		send(OP_INIT, 32'sh7fffffff, 32'sh80000000);
		send(OP_PRED, 0, 0);
		send(OP_CORR, 32'sh80000000, 32'sh7fffffff);
		send(2'd3, 32'sh55555555, 32'shaaaaaaaa);
		send(OP_INIT, 32'sh80000000, 32'sh7fffffff);
		send(OP_CORR, -1, 1);
		send(OP_INIT, 0, 0);
		for (int i = 0; i < 4; i++) send(OP_PRED, 0, 0);
		send(OP_CORR, 32'h00010000, 32'hffff0000);
		drain_and_idle();
		write_reg(CFG_MNOISE, 16'd0);
		write_reg(CFG_PNOISE, 16'd0);
		// zero R and Q: correcting twice collapses P so S becomes singular
		send(OP_INIT, 32'sh00100000, 32'sh00200000);
		send(OP_CORR, 32'sh00110000, 32'sh00210000);
		send(OP_CORR, 32'sh00120000, 32'sh00220000);
		send(OP_PRED, 0, 0);
		send(OP_CORR, 32'sh00130000, 32'sh00230000);
		drain_and_idle();

		// random phases through several noise settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_PNOISE, 16'hffff); write_reg(CFG_MNOISE, 16'hffff); end
				1: begin write_reg(CFG_PNOISE, 16'd655); write_reg(CFG_MNOISE, 16'd6554); end
				2: begin write_reg(CFG_PNOISE, 16'd0); write_reg(CFG_MNOISE, 16'd1); end
				default: begin
					write_reg(CFG_PNOISE, 16'($urandom));
					write_reg(CFG_MNOISE, 16'($urandom));
				end
			endcase
			calm = (ph == 1);
			if (ph == 2) begin
				// long receiver hold while items keep coming
				rx_hold = 1'b1;
				fork
					begin repeat (2000) @(posedge clk); rx_hold = 1'b0; end
					random_phase(20);
				join
			end
			random_phase(230);
			calm = 1'b0;
			drain_and_idle();
		end

		$display("%0d items sent, %0d estimates checked, %0d singular corrections",
			sent, result_count, singular_count);
		if (fail_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
